FILE: hdl/accel_tilt_roll_pitch_macros.svh
// assertion macros shared by the tilt pipeline modules
`ifndef ACCEL_TILT_ROLL_PITCH_MACROS_SVH
`define ACCEL_TILT_ROLL_PITCH_MACROS_SVH

// generic clocked check, off while reset is low
`define ACCTRP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tilt pipeline check failed");

// same check on the house clock and reset names
`define ACCTRP_CHECK(lbl, prop) `ACCTRP_ASSERT(lbl, i_clk, i_rst_n, prop)

`endif

FILE: hdl/acctrp_pkg.sv
// shared constants, types and helpers of the tilt pipeline
package acctrp_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int CORDIC_STAGES   = 18;
    localparam int STAGE_TABLE_LEN = 24;
    localparam int STAGE_COUNT     = (CORDIC_STAGES < STAGE_TABLE_LEN) ?
                                     CORDIC_STAGES : STAGE_TABLE_LEN;

    // samples scaled to a 40-bit fixed point, plus headroom for gain and sign
    localparam int GUARD_BITS = 40 - SAMPLE_BITS;
    localparam int DATA_W     = GUARD_BITS + SAMPLE_BITS + 4;

    // binary angle, 2^32 per turn, with room for the half-turn start
    localparam int ANG_W     = 34;
    localparam int ANG_MAG_W = ANG_W - 1;

    // inverse cordic gain in q20, product split in two partial products
    localparam int GAIN_W   = 20;
    localparam logic [GAIN_W-1:0] INV_GAIN_Q20 = GAIN_W'(636751);
    localparam int MAG_LO_W = 22;
    localparam int MAG_HI_W = DATA_W - 1 - MAG_LO_W;
    localparam int MSUM_W   = DATA_W - 1 + GAIN_W;

    // angle to centidegree conversion
    localparam int CDEG_W     = 16;
    localparam logic [CDEG_W-1:0] TURN_CENTIDEG = CDEG_W'(36000);
    localparam int CPROD_W    = ANG_MAG_W + CDEG_W;
    localparam int CDEG_SHIFT = 32;
    localparam int CDEG_RAW_W = CPROD_W - CDEG_SHIFT;

    localparam int ROLL_W    = 16;
    localparam int PITCH_W   = 15;
    localparam int ROLL_LIM  = 18000;
    localparam int PITCH_LIM = 9000;
    localparam logic [CDEG_RAW_W-1:0] ROLL_LIM_C  = CDEG_RAW_W'(ROLL_LIM);
    localparam logic [CDEG_RAW_W-1:0] PITCH_LIM_C = CDEG_RAW_W'(PITCH_LIM);

    localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(64'sd2147483648);

    // accepting edge to the edge that loads the result registers
    localparam int RESULT_LATENCY = 2 * STAGE_COUNT + 4;

    // atan(2^-i) in binary angle units
    localparam logic [31:0] STAGE_ANGLE [STAGE_TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // sideband that rides along a cordic pass
    typedef struct packed {
        logic                          gate;
        logic signed [SAMPLE_BITS-1:0] ax;
        logic signed [ROLL_W-1:0]      roll;
    } t_tag;

    // clamp a truncated centidegree magnitude and apply the sign
    function automatic logic signed [ROLL_W-1:0] clamp_centideg(
        input logic [CDEG_RAW_W-1:0] raw,
        input logic                  neg,
        input logic [CDEG_RAW_W-1:0] lim
    );
        logic [CDEG_RAW_W-1:0]    c;
        logic signed [ROLL_W-1:0] m;
        c = (raw > lim) ? lim : raw;
        m = signed'(ROLL_W'(c));
        return neg ? -m : m;
    endfunction

endpackage

FILE: hdl/accel_tilt_roll_pitch.sv
// tilt pipeline top: roll and pitch in centidegrees from one accelerometer sample
// the result strobe follows the accepting edge through p0, the roll pass, m1, m2, the pitch pass, q1 and q2
// throughput: one sample per cycle, set by one register per cordic iteration
// in two chained vectoring passes plus two gain and two conversion stages
// the receiver cannot stall, so busy never rises after reset
// reset: synchronous active low, clears all valid bits; busy is high in reset and falls at the first edge after it
`include "accel_tilt_roll_pitch_macros.svh"

module accel_tilt_roll_pitch (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     start,
    input  logic signed [acctrp_pkg::SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [acctrp_pkg::SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [acctrp_pkg::SAMPLE_BITS-1:0] i_accel_z,
    output logic                                     busy,
    output logic                                     o_strobe,
    output logic signed [acctrp_pkg::ROLL_W-1:0]      o_roll_centideg,
    output logic signed [acctrp_pkg::PITCH_W-1:0]     o_pitch_centideg
);

    // ------------------------------------------------------------------
    // request handshake: a request is taken whenever busy is low
    // ------------------------------------------------------------------
    logic r_busy;
    logic w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign w_accept = start && !r_busy;

    // ------------------------------------------------------------------
    // p0: scale samples, fold the left half plane onto the right one
    // ------------------------------------------------------------------
    logic signed [acctrp_pkg::DATA_W-1:0] w_ay_s;
    logic signed [acctrp_pkg::DATA_W-1:0] w_az_s;
    logic                                 w_az_neg;
    logic signed [acctrp_pkg::DATA_W-1:0] n_p0_x;
    logic signed [acctrp_pkg::DATA_W-1:0] n_p0_y;
    logic signed [acctrp_pkg::ANG_W-1:0]  n_p0_a;
    acctrp_pkg::t_tag                     n_p0_tag;

    logic                                 r_p0_vld;
    logic signed [acctrp_pkg::DATA_W-1:0] r_p0_x;
    logic signed [acctrp_pkg::DATA_W-1:0] r_p0_y;
    logic signed [acctrp_pkg::ANG_W-1:0]  r_p0_a;
    acctrp_pkg::t_tag                     r_p0_tag;

    assign w_ay_s   = acctrp_pkg::DATA_W'(i_accel_y) <<< acctrp_pkg::GUARD_BITS;
    assign w_az_s   = acctrp_pkg::DATA_W'(i_accel_z) <<< acctrp_pkg::GUARD_BITS;
    assign w_az_neg = i_accel_z[acctrp_pkg::SAMPLE_BITS-1];

    always_comb begin
        if (w_az_neg) begin
            // negative z: rotate by half a turn, sign of y picks the direction
            n_p0_x = -w_az_s;
            n_p0_y = -w_ay_s;
            n_p0_a = i_accel_y[acctrp_pkg::SAMPLE_BITS-1] ?
                     -acctrp_pkg::HALF_TURN : acctrp_pkg::HALF_TURN;
        end else begin
            n_p0_x = w_az_s;
            n_p0_y = w_ay_s;
            n_p0_a = '0;
        end
        // zero (y, z) vector gives roll 0 and magnitude 0
        n_p0_tag.gate = (i_accel_y != '0) || (i_accel_z != '0);
        n_p0_tag.ax   = i_accel_x;
        n_p0_tag.roll = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_vld <= 1'b0;
        end else begin
            r_p0_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0_x   <= n_p0_x;
        r_p0_y   <= n_p0_y;
        r_p0_a   <= n_p0_a;
        r_p0_tag <= n_p0_tag;
    end

    // ------------------------------------------------------------------
    // roll pass: atan2(y, z) and the scaled magnitude of (z, y)
    // ------------------------------------------------------------------
    logic                                 w_r_vld;
    acctrp_pkg::t_tag                     w_r_tag;
    logic signed [acctrp_pkg::DATA_W-1:0] w_r_x;
    logic signed [acctrp_pkg::ANG_W-1:0]  w_r_a;

    acctrp_cordic u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p0_vld),
        .i_tag   (r_p0_tag),
        .i_x     (r_p0_x),
        .i_y     (r_p0_y),
        .i_a     (r_p0_a),
        .o_valid (w_r_vld),
        .o_tag   (w_r_tag),
        .o_x     (w_r_x),
        .o_a     (w_r_a)
    );

    // ------------------------------------------------------------------
    // m1: gain correction partial products, roll angle times 36000
    // ------------------------------------------------------------------
    logic [acctrp_pkg::DATA_W-2:0]                    w_xc;
    logic [acctrp_pkg::ANG_MAG_W-1:0]                 w_r_abs;
    logic                                             r_m1_vld;
    acctrp_pkg::t_tag                                 r_m1_tag;
    logic [acctrp_pkg::MAG_LO_W+acctrp_pkg::GAIN_W-1:0] r_m1_plo;
    logic [acctrp_pkg::MAG_HI_W+acctrp_pkg::GAIN_W-1:0] r_m1_phi;
    logic [acctrp_pkg::CPROD_W-1:0]                   r_m1_rprod;
    logic                                             r_m1_rneg;

    // negative magnitude is clamped to zero before the gain step
    assign w_xc    = w_r_x[acctrp_pkg::DATA_W-1] ? '0 : w_r_x[acctrp_pkg::DATA_W-2:0];
    assign w_r_abs = w_r_a[acctrp_pkg::ANG_W-1] ? acctrp_pkg::ANG_MAG_W'(-w_r_a) :
                     w_r_a[acctrp_pkg::ANG_MAG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else begin
            r_m1_vld <= w_r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1_tag   <= w_r_tag;
        r_m1_plo   <= w_xc[acctrp_pkg::MAG_LO_W-1:0] * acctrp_pkg::INV_GAIN_Q20;
        r_m1_phi   <= w_xc[acctrp_pkg::DATA_W-2:acctrp_pkg::MAG_LO_W] *
                      acctrp_pkg::INV_GAIN_Q20;
        r_m1_rprod <= w_r_abs * acctrp_pkg::TURN_CENTIDEG;
        r_m1_rneg  <= w_r_a[acctrp_pkg::ANG_W-1];
    end

    // ------------------------------------------------------------------
    // m2: finish magnitude, finish roll, set up the pitch pass
    // ------------------------------------------------------------------
    logic [acctrp_pkg::MSUM_W-1:0]        w_msum;
    logic signed [acctrp_pkg::DATA_W-1:0] w_mag;
    logic signed [acctrp_pkg::DATA_W-1:0] w_ax_s;
    acctrp_pkg::t_tag                     n_m2_tag;

    logic                                 r_m2_vld;
    acctrp_pkg::t_tag                     r_m2_tag;
    logic signed [acctrp_pkg::DATA_W-1:0] r_m2_x;
    logic signed [acctrp_pkg::DATA_W-1:0] r_m2_y;

    assign w_msum = (acctrp_pkg::MSUM_W'(r_m1_phi) << acctrp_pkg::MAG_LO_W) +
                    acctrp_pkg::MSUM_W'(r_m1_plo);
    assign w_mag  = r_m1_tag.gate ?
                    signed'({1'b0, w_msum[acctrp_pkg::GAIN_W +: acctrp_pkg::DATA_W-1]}) : '0;
    assign w_ax_s = acctrp_pkg::DATA_W'(r_m1_tag.ax) <<< acctrp_pkg::GUARD_BITS;

    always_comb begin
        // zero x with zero magnitude gives pitch 0
        n_m2_tag.gate = (r_m1_tag.ax != '0) || (w_mag != '0);
        n_m2_tag.ax   = r_m1_tag.ax;
        n_m2_tag.roll = r_m1_tag.gate ?
                        acctrp_pkg::clamp_centideg(
                            r_m1_rprod[acctrp_pkg::CPROD_W-1:acctrp_pkg::CDEG_SHIFT],
                            r_m1_rneg, acctrp_pkg::ROLL_LIM_C) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_vld <= 1'b0;
        end else begin
            r_m2_vld <= r_m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m2_tag <= n_m2_tag;
        r_m2_x   <= w_mag;
        r_m2_y   <= -w_ax_s;
    end

    // ------------------------------------------------------------------
    // pitch pass: atan2(-x, hypot(y, z)), roll rides in the tag
    // ------------------------------------------------------------------
    logic                                w_p_vld;
    acctrp_pkg::t_tag                    w_p_tag;
    logic signed [acctrp_pkg::ANG_W-1:0] w_p_a;

    acctrp_cordic u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_m2_vld),
        .i_tag   (r_m2_tag),
        .i_x     (r_m2_x),
        .i_y     (r_m2_y),
        .i_a     ('0),
        .o_valid (w_p_vld),
        .o_tag   (w_p_tag),
        .o_x     (),
        .o_a     (w_p_a)
    );

    // ------------------------------------------------------------------
    // q1: pitch angle times 36000
    // ------------------------------------------------------------------
    logic [acctrp_pkg::ANG_MAG_W-1:0] w_p_abs;
    logic                             r_q1_vld;
    acctrp_pkg::t_tag                 r_q1_tag;
    logic [acctrp_pkg::CPROD_W-1:0]   r_q1_pprod;
    logic                             r_q1_pneg;

    assign w_p_abs = w_p_a[acctrp_pkg::ANG_W-1] ? acctrp_pkg::ANG_MAG_W'(-w_p_a) :
                     w_p_a[acctrp_pkg::ANG_MAG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_vld <= 1'b0;
        end else begin
            r_q1_vld <= w_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q1_tag   <= w_p_tag;
        r_q1_pprod <= w_p_abs * acctrp_pkg::TURN_CENTIDEG;
        r_q1_pneg  <= w_p_a[acctrp_pkg::ANG_W-1];
    end

    // ------------------------------------------------------------------
    // q2: result registers, strobe high for one cycle per sample
    // ------------------------------------------------------------------
    logic signed [acctrp_pkg::ROLL_W-1:0]  w_pitch_full;
    logic                                  r_out_strobe;
    logic signed [acctrp_pkg::ROLL_W-1:0]  r_out_roll;
    logic signed [acctrp_pkg::PITCH_W-1:0] r_out_pitch;

    assign w_pitch_full = r_q1_tag.gate ?
                          acctrp_pkg::clamp_centideg(
                              r_q1_pprod[acctrp_pkg::CPROD_W-1:acctrp_pkg::CDEG_SHIFT],
                              r_q1_pneg, acctrp_pkg::PITCH_LIM_C) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_strobe <= 1'b0;
        end else begin
            r_out_strobe <= r_q1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_roll  <= r_q1_tag.roll;
        r_out_pitch <= acctrp_pkg::PITCH_W'(w_pitch_full);
    end

    assign o_strobe         = r_out_strobe;
    assign o_roll_centideg  = r_out_roll;
    assign o_pitch_centideg = r_out_pitch;

    `ACCTRP_CHECK(a_result_latency, w_accept |-> ##(acctrp_pkg::RESULT_LATENCY + 1) o_strobe)
    `ACCTRP_CHECK(a_roll_range, o_strobe |-> ((o_roll_centideg <= acctrp_pkg::ROLL_LIM) && (o_roll_centideg >= -acctrp_pkg::ROLL_LIM)))
    `ACCTRP_CHECK(a_pitch_range, o_strobe |-> ((o_pitch_centideg <= acctrp_pkg::PITCH_LIM) && (o_pitch_centideg >= -acctrp_pkg::PITCH_LIM)))

endmodule

FILE: hdl/acctrp_cordic.sv
// pipelined vectoring cordic, one register stage per iteration
`include "accel_tilt_roll_pitch_macros.svh"

module acctrp_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  acctrp_pkg::t_tag                    i_tag,
    input  logic signed [acctrp_pkg::DATA_W-1:0] i_x,
    input  logic signed [acctrp_pkg::DATA_W-1:0] i_y,
    input  logic signed [acctrp_pkg::ANG_W-1:0]  i_a,
    output logic                                o_valid,
    output acctrp_pkg::t_tag                    o_tag,
    output logic signed [acctrp_pkg::DATA_W-1:0] o_x,
    output logic signed [acctrp_pkg::ANG_W-1:0]  o_a
);

    logic                                r_v   [acctrp_pkg::STAGE_COUNT];
    acctrp_pkg::t_tag                    r_tag [acctrp_pkg::STAGE_COUNT];
    logic signed [acctrp_pkg::DATA_W-1:0] r_x   [acctrp_pkg::STAGE_COUNT];
    logic signed [acctrp_pkg::DATA_W-1:0] r_y   [acctrp_pkg::STAGE_COUNT-1];
    logic signed [acctrp_pkg::ANG_W-1:0]  r_a   [acctrp_pkg::STAGE_COUNT];

    for (genvar j = 0; j < acctrp_pkg::STAGE_COUNT; j++) begin : g_stage
        logic                                w_v;
        acctrp_pkg::t_tag                    w_tag;
        logic signed [acctrp_pkg::DATA_W-1:0] w_x;
        logic signed [acctrp_pkg::DATA_W-1:0] w_y;
        logic signed [acctrp_pkg::ANG_W-1:0]  w_a;
        logic signed [acctrp_pkg::DATA_W-1:0] w_xs;
        logic signed [acctrp_pkg::DATA_W-1:0] w_ys;
        logic signed [acctrp_pkg::ANG_W-1:0]  w_ang;
        logic signed [acctrp_pkg::DATA_W-1:0] n_x;
        logic signed [acctrp_pkg::ANG_W-1:0]  n_a;

        if (j == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_tag = i_tag;
            assign w_x   = i_x;
            assign w_y   = i_y;
            assign w_a   = i_a;
        end else begin : g_next
            assign w_v   = r_v[j-1];
            assign w_tag = r_tag[j-1];
            assign w_x   = r_x[j-1];
            assign w_y   = r_y[j-1];
            assign w_a   = r_a[j-1];
        end

        // floor shifts
        assign w_xs  = w_x >>> j;
        assign w_ys  = w_y >>> j;
        assign w_ang = signed'(acctrp_pkg::ANG_W'(acctrp_pkg::STAGE_ANGLE[j]));

        always_comb begin
            if (w_y[acctrp_pkg::DATA_W-1]) begin
                n_x = w_x - w_ys;
                n_a = w_a - w_ang;
            end else begin
                n_x = w_x + w_ys;
                n_a = w_a + w_ang;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag[j] <= w_tag;
            r_x[j]   <= n_x;
            r_a[j]   <= n_a;
        end

        // last iteration drops y, only x, the angle, the tag and valid leave the pass
        if (j < acctrp_pkg::STAGE_COUNT - 1) begin : g_y
            always_ff @(posedge i_clk) begin
                r_y[j] <= w_y[acctrp_pkg::DATA_W-1] ? (w_y + w_xs) : (w_y - w_xs);
            end
        end
    end

    assign o_valid = r_v[acctrp_pkg::STAGE_COUNT-1];
    assign o_tag   = r_tag[acctrp_pkg::STAGE_COUNT-1];
    assign o_x     = r_x[acctrp_pkg::STAGE_COUNT-1];
    assign o_a     = r_a[acctrp_pkg::STAGE_COUNT-1];

    `ACCTRP_CHECK(a_valid_through, i_valid |-> ##(acctrp_pkg::STAGE_COUNT) o_valid)
    `ACCTRP_CHECK(a_bubble_through, !i_valid |-> ##(acctrp_pkg::STAGE_COUNT) !o_valid)
    `ACCTRP_CHECK(a_x_nonneg, (i_valid && !i_x[acctrp_pkg::DATA_W-1]) |-> ##(acctrp_pkg::STAGE_COUNT) !o_x[acctrp_pkg::DATA_W-1])

endmodule

FILE: tb/tilt_result_checker.sv
`timescale 1ns / 100ps
// result checker for the tilt pipeline: predicts roll and pitch per request and compares
module tilt_result_checker (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_start,
    input  logic                                      i_busy,
    input  logic signed [acctrp_pkg::SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [acctrp_pkg::SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [acctrp_pkg::SAMPLE_BITS-1:0] i_accel_z,
    input  logic                                      i_strobe,
    input  logic signed [acctrp_pkg::ROLL_W-1:0]      i_roll_centideg,
    input  logic signed [acctrp_pkg::PITCH_W-1:0]     i_pitch_centideg,
    output int                                        o_fail_count,
    output int                                        o_pending,
    output int                                        o_checked
);

    localparam int     SAMPLE_BITS   = acctrp_pkg::SAMPLE_BITS;
    localparam int     CORDIC_STAGES = acctrp_pkg::CORDIC_STAGES;
    localparam int     ROLL_W        = acctrp_pkg::ROLL_W;
    localparam int     PITCH_W       = acctrp_pkg::PITCH_W;
    localparam int     ROTATIONS    = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
    localparam int     FRAC_SHIFT   = 40 - SAMPLE_BITS;
    localparam longint HALF_REV     = 64'sd2147483648;
    localparam longint ROLL_CLAMP   = 18000;
    localparam longint PITCH_CLAMP  = 9000;
    localparam int     PRINT_LIMIT  = 30;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] ax;
        logic signed [SAMPLE_BITS-1:0] ay;
        logic signed [SAMPLE_BITS-1:0] az;
        logic signed [ROLL_W-1:0]      roll;
        logic signed [PITCH_W-1:0]     pitch;
    } t_tilt;

    typedef struct packed {
        longint x;
        longint y;
        longint a;
    } t_rotor;

    t_tilt tilt_expected_q[$];
    int    fail_tally    = 0;
    int    checked_tally = 0;
    int    pending_now   = 0;

    assign o_fail_count = fail_tally;
    assign o_pending    = pending_now;
    assign o_checked    = checked_tally;

    // atan(2^-i) in units of 2^32 per turn
    function automatic longint atan_step(int i);
        case (i)
            0:  return 536870912;
            1:  return 316933406;
            2:  return 167458907;
            3:  return 85004756;
            4:  return 42667331;
            5:  return 21354465;
            6:  return 10679838;
            7:  return 5340245;
            8:  return 2670163;
            9:  return 1335087;
            10: return 667544;
            11: return 333772;
            12: return 166886;
            13: return 83443;
            14: return 41722;
            15: return 20861;
            16: return 10430;
            17: return 5215;
            18: return 2608;
            19: return 1304;
            20: return 652;
            21: return 326;
            22: return 163;
            default: return 81;
        endcase
    endfunction

    // vectoring rotation, drives y toward zero, shifts floor toward minus infinity
    function automatic t_rotor cordic_vectoring(t_rotor v);
        longint x, y, a, xs, ys;
        x = v.x;
        y = v.y;
        a = v.a;
        for (int i = 0; i < ROTATIONS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                a = a + atan_step(i);
            end else begin
                x = x - ys;
                y = y + xs;
                a = a - atan_step(i);
            end
        end
        v.x = x;
        v.y = y;
        v.a = a;
        return v;
    endfunction

    // truncate toward zero, then clamp
    function automatic longint turn_to_centideg(longint a, longint lim);
        logic [63:0] prod;
        longint      c;
        if (a >= 0) begin
            prod = unsigned'(a) * 64'd36000;
            c    = longint'(prod >> 32);
        end else begin
            prod = unsigned'(-a) * 64'd36000;
            c    = -longint'(prod >> 32);
        end
        if (c > lim)
            c = lim;
        if (c < -lim)
            c = -lim;
        return c;
    endfunction

    function automatic t_tilt predict_tilt(
        input logic signed [SAMPLE_BITS-1:0] sx,
        input logic signed [SAMPLE_BITS-1:0] sy,
        input logic signed [SAMPLE_BITS-1:0] sz
    );
        longint      ax, ay, az, roll, pitch, mag;
        logic [63:0] prod;
        t_rotor      r;
        t_tilt       t;
        ax    = sx;
        ay    = sy;
        az    = sz;
        roll  = 0;
        pitch = 0;
        mag   = 0;
        if (ay != 0 || az != 0) begin
            r.x = az <<< FRAC_SHIFT;
            r.y = ay <<< FRAC_SHIFT;
            r.a = 0;
            if (az < 0) begin
                r.a = (ay >= 0) ? HALF_REV : -HALF_REV;
                r.x = -r.x;
                r.y = -r.y;
            end
            r    = cordic_vectoring(r);
            roll = turn_to_centideg(r.a, ROLL_CLAMP);
            if (r.x < 0)
                r.x = 0;
            prod = unsigned'(r.x) * 64'd636751;
            mag  = longint'(prod >> 20);
        end
        if (ax != 0 || mag != 0) begin
            r.x   = mag;
            r.y   = -(ax <<< FRAC_SHIFT);
            r.a   = 0;
            r     = cordic_vectoring(r);
            pitch = turn_to_centideg(r.a, PITCH_CLAMP);
        end
        t.ax    = sx;
        t.ay    = sy;
        t.az    = sz;
        t.roll  = roll[ROLL_W-1:0];
        t.pitch = pitch[PITCH_W-1:0];
        return t;
    endfunction

    task automatic report_mismatch(input string what);
        if (fail_tally < PRINT_LIMIT)
            $display("%0t ns: mismatch: %s", $time, what);
        fail_tally++;
    endtask

    always @(posedge i_clk) begin : watch
        t_tilt want;
        if (i_rst_n) begin
            if (i_strobe) begin
                if (tilt_expected_q.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = tilt_expected_q.pop_front();
                    checked_tally++;
                    if (i_roll_centideg !== want.roll)
                        report_mismatch($sformatf("roll of (%0d,%0d,%0d) is %0d, want %0d",
                            want.ax, want.ay, want.az, i_roll_centideg, want.roll));
                    if (i_pitch_centideg !== want.pitch)
                        report_mismatch($sformatf("pitch of (%0d,%0d,%0d) is %0d, want %0d",
                            want.ax, want.ay, want.az, i_pitch_centideg, want.pitch));
                end
            end
            if (i_start && !i_busy)
                tilt_expected_q.push_back(predict_tilt(i_accel_x, i_accel_y, i_accel_z));
        end
        pending_now = tilt_expected_q.size();
    end

endmodule

FILE: tb/tb_accel_tilt_roll_pitch.sv
`timescale 1ns / 100ps
// top of the tilt pipeline testbench: clock, reset, sample requests and verdict
module tb_accel_tilt_roll_pitch;

    localparam int SAMPLE_BITS    = acctrp_pkg::SAMPLE_BITS;
    localparam int ROLL_W         = acctrp_pkg::ROLL_W;
    localparam int PITCH_W        = acctrp_pkg::PITCH_W;

    // stimulus volume and run guards
    localparam int RANDOM_REQUESTS = 1080;
    localparam int MAX_GAP         = 18;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = acctrp_pkg::RESULT_LATENCY + 8;

    // how one random field value is drawn
    typedef enum int {
        FIELD_FULL,
        FIELD_SMALL,
        FIELD_ZERO,
        FIELD_EXTREME,
        FIELD_LARGE
    } t_field_kind;

    // how one random sample is shaped
    typedef enum int {
        SHAPE_FULL,
        SHAPE_SMALL,
        SHAPE_ONE_ZERO,
        SHAPE_EXTREME,
        SHAPE_NEAR_AXIS,
        SHAPE_NEAR_HALF_TURN
    } t_sample_shape;

    logic                          i_clk            = 1'b0;
    logic                          i_rst_n          = 1'b0;
    logic                          start            = 1'b0;
    logic signed [SAMPLE_BITS-1:0] i_accel_x        = '0;
    logic signed [SAMPLE_BITS-1:0] i_accel_y        = '0;
    logic signed [SAMPLE_BITS-1:0] i_accel_z        = '0;
    logic                          busy;
    logic                          o_strobe;
    logic signed [ROLL_W-1:0]      o_roll_centideg;
    logic signed [PITCH_W-1:0]     o_pitch_centideg;

    int fail_count;
    int pending;
    int checked;
    int idle_cycles     = 0;
    int n_requests      = 0;
    int n_left_half     = 0;
    int n_zero_yz       = 0;
    bit no_idle_stretch = 1'b0;

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    accel_tilt_roll_pitch uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .i_accel_x        (i_accel_x),
        .i_accel_y        (i_accel_y),
        .i_accel_z        (i_accel_z),
        .busy             (busy),
        .o_strobe         (o_strobe),
        .o_roll_centideg  (o_roll_centideg),
        .o_pitch_centideg (o_pitch_centideg)
    );

    tilt_result_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_accel_x        (i_accel_x),
        .i_accel_y        (i_accel_y),
        .i_accel_z        (i_accel_z),
        .i_strobe         (o_strobe),
        .i_roll_centideg  (o_roll_centideg),
        .i_pitch_centideg (o_pitch_centideg),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    // watchdog: cycles with neither a request nor a result accepted
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("tb_accel_tilt_roll_pitch failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one request: optional idle gap, then hold start until busy is low at an edge
    // busy is sampled at the falling edge, where it is stable for the coming rising edge
    task automatic issue_sample(
        input logic signed [SAMPLE_BITS-1:0] x,
        input logic signed [SAMPLE_BITS-1:0] y,
        input logic signed [SAMPLE_BITS-1:0] z
    );
        int   gap;
        logic taken;
        gap = $urandom_range(0, MAX_GAP);
        // a third of the requests come back to back, plus whole stretches without gaps
        if (no_idle_stretch || $urandom_range(0, 2) == 0)
            gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_accel_x <= x;
        i_accel_y <= y;
        i_accel_z <= z;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end
        n_requests++;
        if (z < 0)
            n_left_half++;
        if (y == 0 && z == 0)
            n_zero_yz++;
    endtask

    // hold the request side off until every outstanding result has come back
    // the count is read at falling edges, after the checker has queued the last request
    task automatic hold_until_drained();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] draw_field(t_field_kind kind);
        logic signed [SAMPLE_BITS-1:0] v;
        case (kind)
            FIELD_SMALL: begin
                v = SAMPLE_BITS'($urandom_range(0, 16));
                v = v - 16'sd8;
            end
            FIELD_ZERO:
                v = '0;
            FIELD_EXTREME: begin
                case ($urandom_range(0, 5))
                    0:       v = -16'sd32768;
                    1:       v = -16'sd32767;
                    2:       v = -16'sd1;
                    3:       v = 16'sd1;
                    4:       v = 16'sd32767;
                    default: v = '0;
                endcase
            end
            FIELD_LARGE: begin
                v = SAMPLE_BITS'($urandom_range(30000, 32767));
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            default:
                v = SAMPLE_BITS'($urandom);
        endcase
        return v;
    endfunction

    task automatic issue_random_sample();
        t_sample_shape                 shape;
        logic signed [SAMPLE_BITS-1:0] x, y, z;
        int                            pick;
        pick = $urandom_range(0, 9);
        // half the samples are fully random, the rest aim at small values, zeros, extremes, axes and the half turn
        if (pick < 5)
            shape = SHAPE_FULL;
        else
            shape = t_sample_shape'(pick - 4);
        x = draw_field(FIELD_FULL);
        y = draw_field(FIELD_FULL);
        z = draw_field(FIELD_FULL);
        case (shape)
            SHAPE_SMALL: begin
                x = draw_field(FIELD_SMALL);
                y = draw_field(FIELD_SMALL);
                z = draw_field(FIELD_SMALL);
            end
            SHAPE_ONE_ZERO: begin
                case ($urandom_range(0, 3))
                    0:       x = draw_field(FIELD_ZERO);
                    1:       y = draw_field(FIELD_ZERO);
                    2:       z = draw_field(FIELD_ZERO);
                    default: begin
                        y = draw_field(FIELD_ZERO);
                        z = draw_field(FIELD_ZERO);
                    end
                endcase
            end
            SHAPE_EXTREME: begin
                x = draw_field(FIELD_EXTREME);
                y = draw_field(FIELD_EXTREME);
                z = draw_field(FIELD_EXTREME);
            end
            SHAPE_NEAR_AXIS: begin
                // one dominant axis, pitch or roll close to a right angle or the clamp
                x = draw_field(FIELD_SMALL);
                y = draw_field(FIELD_SMALL);
                z = draw_field(FIELD_SMALL);
                case ($urandom_range(0, 2))
                    0:       x = draw_field(FIELD_LARGE);
                    1:       y = draw_field(FIELD_LARGE);
                    default: z = draw_field(FIELD_LARGE);
                endcase
            end
            SHAPE_NEAR_HALF_TURN: begin
                // z negative with small y, roll near plus or minus 180 degrees
                y = draw_field(FIELD_SMALL);
                z = draw_field(FIELD_LARGE);
                if (z > 0)
                    z = -z;
            end
            default: ;
        endcase
        issue_sample(x, y, z);
    endtask

    initial begin
        // synchronous reset, then release
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero vectors, axes, left half plane, field extremes
        issue_sample(16'sd0, 16'sd0, 16'sd0);
        issue_sample(16'sd5, 16'sd0, 16'sd0);
        issue_sample(-16'sd5, 16'sd0, 16'sd0);
        issue_sample(-16'sd32768, 16'sd0, 16'sd0);
        issue_sample(16'sd32767, 16'sd0, 16'sd0);
        issue_sample(16'sd0, 16'sd0, 16'sd32767);
        issue_sample(16'sd0, 16'sd0, -16'sd32768);
        issue_sample(16'sd0, 16'sd32767, 16'sd0);
        issue_sample(16'sd0, -16'sd32768, 16'sd0);
        issue_sample(16'sd0, 16'sd1, -16'sd32768);
        issue_sample(16'sd0, -16'sd1, -16'sd32768);
        issue_sample(16'sd0, 16'sd0, -16'sd1);
        issue_sample(16'sd0, -16'sd32768, -16'sd32768);
        issue_sample(16'sd0, 16'sd32767, -16'sd32768);
        issue_sample(-16'sd32768, -16'sd32768, -16'sd32768);
        issue_sample(16'sd32767, 16'sd32767, 16'sd32767);
        issue_sample(-16'sd32768, 16'sd32767, -16'sd32768);
        issue_sample(16'sd32767, -16'sd32768, 16'sd32767);
        issue_sample(16'sd1, 16'sd1, 16'sd1);
        issue_sample(-16'sd1, -16'sd1, -16'sd1);
        issue_sample(16'sd100, 16'sd0, 16'sd1);
        issue_sample(16'sd0, 16'sd1, 16'sd0);
        issue_sample(-16'sd32768, 16'sd1, 16'sd0);

        // let the pipeline run dry once before the random part
        hold_until_drained();

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            // every third block of 60 requests runs without gaps
            no_idle_stretch = ((n / 60) % 3) == 1;
            if (n == RANDOM_REQUESTS / 2)
                hold_until_drained();
            issue_random_sample();
        end
        start <= 1'b0;

        // wait for the last results, then watch for strays
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d samples (%0d with z negative, %0d with y and z both zero)",
                 n_requests, n_left_half, n_zero_yz);
        $display("checked %0d roll and pitch results, %0d mismatches", checked, fail_count);
        if (fail_count == 0)
            $display("tb_accel_tilt_roll_pitch passed");
        else
            $display("tb_accel_tilt_roll_pitch failed");
        $finish;
    end

endmodule

FILE: accel_tilt_roll_pitch.f
+incdir+hdl
hdl/acctrp_pkg.sv
hdl/acctrp_cordic.sv
hdl/accel_tilt_roll_pitch.sv
tb/tilt_result_checker.sv
tb/tb_accel_tilt_roll_pitch.sv
